>>> src/ipsnr_pkg.sv
// Shared types, constants and elaboration-time helpers for the PSNR accumulator.
// No dependencies.
`default_nettype none
package ipsnr_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 56;
   localparam int MSE_W    = 32;
   localparam int LOG_W    = 29;
   localparam int PSNR_W   = 15;

   localparam logic [PSNR_W-1:0] PSNR_MAX = 15'd24700;
   localparam logic [31:0] PEAK_Q1616 = 32'd4261478400;
   // 10*log10(2) in Q2.30
   localparam logic [31:0] K_Q30 = 32'd3232284966;

   // Format codes
   localparam logic [2:0] FMT_INVALID = 3'd0;
   localparam logic [2:0] FMT_RGB     = 3'd1;
   localparam logic [2:0] FMT_BGR     = 3'd2;
   localparam logic [2:0] FMT_RGBA    = 3'd3;
   localparam logic [2:0] FMT_BGRA    = 3'd4;
   localparam logic [2:0] FMT_GRAY    = 3'd5;
   localparam logic [2:0] FMT_GRAYA   = 3'd6;

   // Status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FORMAT   = 2'd1;
   localparam logic [1:0] ST_DIMS     = 2'd2;
   localparam logic [1:0] ST_INVALID  = 2'd3;

   // Register indexes
   localparam logic [2:0] REG_FORMAT_A = 3'd0;
   localparam logic [2:0] REG_FORMAT_B = 3'd1;
   localparam logic [2:0] REG_WIDTH_A  = 3'd2;
   localparam logic [2:0] REG_HEIGHT_A = 3'd3;
   localparam logic [2:0] REG_WIDTH_B  = 3'd4;
   localparam logic [2:0] REG_HEIGHT_B = 3'd5;

   typedef struct packed {
      logic clear;
      logic add;
   } lane_ctl_type;

   function automatic logic [2:0] fmt_norm(input logic [2:0] f);
      return (f > FMT_GRAYA) ? FMT_INVALID : f;
   endfunction

   function automatic logic fmt_compatible(input logic [2:0] x, input logic [2:0] y);
      logic ok;
      ok = (x == y)
         || (x == FMT_RGB  && y == FMT_RGBA) || (x == FMT_RGBA  && y == FMT_RGB)
         || (x == FMT_BGR  && y == FMT_BGRA) || (x == FMT_BGRA  && y == FMT_BGR)
         || (x == FMT_GRAY && y == FMT_GRAYA) || (x == FMT_GRAYA && y == FMT_GRAY);
      return ok;
   endfunction

   // log2 in Q.24, evaluated at elaboration for the peak constant only
   function automatic logic [LOG_W-1:0] log2_q24_const(input logic [31:0] x);
      int unsigned n;
      longint unsigned m;
      longint unsigned res;
      n = 31;
      while (n > 0 && x[n] == 1'b0) n--;
      m = longint'(x) << (31 - n);
      res = longint'(n) << 24;
      for (int i = 23; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            res = res | (64'd1 << i);
         end
      end
      return res[LOG_W-1:0];
   endfunction

endpackage
`default_nettype wire

>>> src/image_psnr_accumulator_top.sv
// Per-channel MSE and PSNR over two streamed images.
// Depends on ipsnr_pkg, ipsnr_lane, ipsnr_div and ipsnr_log.
// While an image streams in, one pixel request is taken every cycle; the lanes
// square and sum each channel side by side. On the pixel that completes the
// image, the block stops taking requests for the finish: a drain state lets the
// last sum settle, then per emitted channel a start state, the bit-serial divider,
// the log unit (normalising shifts, then one squaring per fraction bit) and the
// scaling product where the MSE calls for them, and the output hand-over.
// A configuration error gives one status result for each request,
// with its pixel dropped and the sums cleared.
`default_nettype none
module image_psnr_accumulator_top
   import ipsnr_pkg::*;
#(
   parameter int MAX_DIM      = 4096,
   parameter int NUM_CHANNELS = 3
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [SAMPLE_W-1:0] req_a_ch0,
   input  wire logic [SAMPLE_W-1:0] req_a_ch1,
   input  wire logic [SAMPLE_W-1:0] req_a_ch2,
   input  wire logic [SAMPLE_W-1:0] req_b_ch0,
   input  wire logic [SAMPLE_W-1:0] req_b_ch1,
   input  wire logic [SAMPLE_W-1:0] req_b_ch2,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [1:0]          rsp_channel,
   output logic      [1:0]          rsp_status,
   output logic      [MSE_W-1:0]    rsp_mse,
   output logic      [PSNR_W-1:0]   rsp_psnr_db,
   output logic                     rsp_psnr_infinite,
   output logic                     rsp_last,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [2:0]          csr_index,
   input  wire logic [12:0]         csr_data
);

   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int CNT_W   = 2 * DIM_W;
   localparam int CH_USED = (NUM_CHANNELS > 3) ? 3 : NUM_CHANNELS;
   localparam logic [LOG_W-1:0] LR_Q24 = log2_q24_const(PEAK_Q1616);

   localparam logic [2:0] S_ACC   = 3'd0;
   localparam logic [2:0] S_DRAIN = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_LOG   = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;
   localparam logic [2:0] S_START = 3'd6;

   // configuration registers
   logic [2:0]  fmt_a_ff, fmt_b_ff;
   logic [12:0] wid_a_ff, hgt_a_ff, wid_b_ff, hgt_b_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_a_ff <= FMT_RGB;
         fmt_b_ff <= FMT_RGB;
         wid_a_ff <= 13'd1;
         hgt_a_ff <= 13'd1;
         wid_b_ff <= 13'd1;
         hgt_b_ff <= 13'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_FORMAT_A: fmt_a_ff <= csr_data[2:0];
            REG_FORMAT_B: fmt_b_ff <= csr_data[2:0];
            REG_WIDTH_A:  wid_a_ff <= csr_data;
            REG_HEIGHT_A: hgt_a_ff <= csr_data;
            REG_WIDTH_B:  wid_b_ff <= csr_data;
            REG_HEIGHT_B: hgt_b_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // configuration checks and image size
   logic [2:0]       fa, fb;
   logic [1:0]       cfg_status;
   logic [DIM_W-1:0] wid_c, hgt_c;
   logic [CNT_W-1:0] total;
   logic [1:0]       nres;

   function automatic logic [DIM_W-1:0] dim_clamp(input logic [12:0] d);
      logic [31:0] w;
      w = {19'd0, d};
      if (w == 32'd0) w = 32'd1;
      else if (w > MAX_DIM) w = MAX_DIM;
      return w[DIM_W-1:0];
   endfunction

   always_comb begin
      fa = fmt_norm(fmt_a_ff);
      fb = fmt_norm(fmt_b_ff);
      if (!fmt_compatible(fa, fb)) cfg_status = ST_FORMAT;
      else if (wid_a_ff != wid_b_ff || hgt_a_ff != hgt_b_ff) cfg_status = ST_DIMS;
      else if (fa == FMT_INVALID) cfg_status = ST_INVALID;
      else cfg_status = ST_OK;
      wid_c = dim_clamp(wid_a_ff);
      hgt_c = dim_clamp(hgt_a_ff);
      total = {{DIM_W{1'b0}}, wid_c} * {{DIM_W{1'b0}}, hgt_c};
      nres  = (fa >= FMT_GRAY) ? 2'd1 : 2'(CH_USED);
   end

   // sequencer state
   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [1:0]        ch_ff, ch_in;
   logic              accept;
   lane_ctl_type      lane_ctl;

   // lanes
   logic [SUM_W-1:0]    sums [0:3];
   logic [SAMPLE_W-1:0] a_s  [0:2];
   logic [SAMPLE_W-1:0] b_s  [0:2];

   assign a_s[0] = req_a_ch0;
   assign a_s[1] = req_a_ch1;
   assign a_s[2] = req_a_ch2;
   assign b_s[0] = req_b_ch0;
   assign b_s[1] = req_b_ch1;
   assign b_s[2] = req_b_ch2;

   for (genvar g = 0; g < 4; g++) begin : g_lane
      if (g < CH_USED) begin : g_on
         ipsnr_lane u_lane (
            .clock (clock),
            .reset (reset),
            .ctl   (lane_ctl),
            .a     (a_s[g]),
            .b     (b_s[g]),
            .sum   (sums[g])
         );
      end else begin : g_off
         assign sums[g] = '0;
      end
   end

   // shared divider and log units
   logic              div_start, div_done;
   logic [SUM_W-1:0]  quo;
   logic              log_start, log_done;
   logic [LOG_W-1:0]  lm;
   logic [MSE_W-1:0]  mse_sat;

   ipsnr_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sums[ch_ff]),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (quo)
   );

   assign mse_sat = (|quo[SUM_W-1:MSE_W]) ? {MSE_W{1'b1}} : quo[MSE_W-1:0];

   ipsnr_log u_log (
      .clock  (clock),
      .reset  (reset),
      .start  (log_start),
      .x      (mse_sat),
      .done   (log_done),
      .result (lm)
   );

   // scaling product and result registers
   logic [LOG_W+31:0]  prod_ff, prod_in;
   logic [LOG_W+32:0]  rounded;
   logic [15:0]        v;
   logic [1:0]         ch_o_ff, ch_o_in;
   logic [1:0]         st_o_ff, st_o_in;
   logic [MSE_W-1:0]   mse_o_ff, mse_o_in;
   logic [PSNR_W-1:0]  psnr_o_ff, psnr_o_in;
   logic               inf_o_ff, inf_o_in;
   logic               last_o_ff, last_o_in;

   assign req_stall = (state_ff != S_ACC);
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      rounded   = {1'b0, prod_ff} + ((LOG_W+33)'(1) << 45);
      v         = rounded[61:46];
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      ch_in     = ch_ff;
      prod_in   = prod_ff;
      ch_o_in   = ch_o_ff;
      st_o_in   = st_o_ff;
      mse_o_in  = mse_o_ff;
      psnr_o_in = psnr_o_ff;
      inf_o_in  = inf_o_ff;
      last_o_in = last_o_ff;
      lane_ctl  = '{clear: 1'b0, add: 1'b0};
      div_start = 1'b0;
      log_start = 1'b0;
      unique case (state_ff)
         S_ACC: begin
            if (accept) begin
               if (cfg_status != ST_OK) begin
                  // drop the pixel and report the error
                  lane_ctl.clear = 1'b1;
                  cnt_in    = '0;
                  ch_o_in   = 2'd0;
                  st_o_in   = cfg_status;
                  mse_o_in  = '0;
                  psnr_o_in = '0;
                  inf_o_in  = 1'b0;
                  last_o_in = 1'b1;
                  state_in  = S_OUT;
               end else begin
                  lane_ctl.add = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
                  if (cnt_in >= total) begin
                     ch_in    = 2'd0;
                     state_in = S_DRAIN;
                  end
               end
            end
         end
         S_DRAIN: begin
            // let the last square land in the sums
            state_in = S_START;
         end
         S_START: begin
            div_start = 1'b1;
            state_in  = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               ch_o_in   = ch_ff;
               st_o_in   = ST_OK;
               mse_o_in  = mse_sat;
               last_o_in = (ch_ff + 2'd1 == nres);
               if (mse_sat == '0) begin
                  psnr_o_in = PSNR_MAX;
                  inf_o_in  = 1'b1;
                  state_in  = S_OUT;
               end else begin
                  inf_o_in  = 1'b0;
                  log_start = 1'b1;
                  state_in  = S_LOG;
               end
            end
         end
         S_LOG: begin
            if (log_done) begin
               if (lm >= LR_Q24) begin
                  psnr_o_in = '0;
                  state_in  = S_OUT;
               end else begin
                  prod_in  = {32'd0, LR_Q24 - lm} * {{LOG_W{1'b0}}, K_Q30};
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            psnr_o_in = (v > {1'b0, PSNR_MAX}) ? PSNR_MAX : v[PSNR_W-1:0];
            state_in  = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               if (last_o_ff) begin
                  lane_ctl.clear = 1'b1;
                  cnt_in   = '0;
                  state_in = S_ACC;
               end else begin
                  // advance to the next channel before starting the divider
                  ch_in    = ch_ff + 2'd1;
                  state_in = S_START;
               end
            end
         end
         default: state_in = S_ACC;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ACC;
         cnt_ff   <= '0;
         ch_ff    <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ch_ff    <= ch_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      ch_o_ff   <= ch_o_in;
      st_o_ff   <= st_o_in;
      mse_o_ff  <= mse_o_in;
      psnr_o_ff <= psnr_o_in;
      inf_o_ff  <= inf_o_in;
      last_o_ff <= last_o_in;
   end

   assign rsp_valid         = (state_ff == S_OUT);
   assign rsp_channel       = ch_o_ff;
   assign rsp_status        = st_o_ff;
   assign rsp_mse           = mse_o_ff;
   assign rsp_psnr_db       = psnr_o_ff;
   assign rsp_psnr_infinite = inf_o_ff;
   assign rsp_last          = last_o_ff;

   // no request is taken while a result waits
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while a result is pending");

   // an error status is always a single, final result
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_last && rsp_mse == '0)
      else $error("error result not final");

   // infinite PSNR only with zero MSE and saturated dB
   a_inf: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_psnr_infinite |-> rsp_mse == '0 && rsp_psnr_db == PSNR_MAX)
      else $error("infinite flag without zero mse");

endmodule
`default_nettype wire

>>> src/ipsnr_lane.sv
// One channel lane: absolute difference, registered square, sum of squares.
// Depends on ipsnr_pkg.
`default_nettype none
module ipsnr_lane
   import ipsnr_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire lane_ctl_type        ctl,
   input  wire logic [SAMPLE_W-1:0] a,
   input  wire logic [SAMPLE_W-1:0] b,
   output logic      [SUM_W-1:0]    sum
);

   logic [SAMPLE_W-1:0]   diff;
   logic [2*SAMPLE_W-1:0] sq_ff, sq_in;
   logic                  sq_vld_ff, sq_vld_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;

   // square the absolute difference
   always_comb begin
      diff      = (a >= b) ? (a - b) : (b - a);
      sq_in     = {{SAMPLE_W{1'b0}}, diff} * {{SAMPLE_W{1'b0}}, diff};
      sq_vld_in = ctl.add & ~ctl.clear;
   end

   // add the previous square, or drop everything on clear
   always_comb begin
      if (ctl.clear) begin
         sum_in = '0;
      end else if (sq_vld_ff) begin
         sum_in = sum_ff + {{(SUM_W-2*SAMPLE_W){1'b0}}, sq_ff};
      end else begin
         sum_in = sum_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
         sum_ff    <= '0;
      end else begin
         sq_vld_ff <= sq_vld_in;
         sum_ff    <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

   assign sum = sum_ff;

endmodule
`default_nettype wire

>>> src/ipsnr_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing beyond its own parameters.
`default_nettype none
module ipsnr_div #(
   parameter int DVD_W = 56,
   parameter int DVS_W = 26
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output logic                  done,
   output logic      [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;
   logic             ge;

   // one shift-subtract step
   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      ge      = trial >= {1'b0, dvs_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DVS_W'(trial - {1'b0, dvs_ff}) : trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

>>> src/ipsnr_log.sv
// Iterative log2 in Q.24: one normalising shift per cycle, then one squaring per
// fraction bit. Depends on ipsnr_pkg.
`default_nettype none
module ipsnr_log
   import ipsnr_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [31:0]      x,
   output logic                  done,
   output logic      [LOG_W-1:0] result
);

   localparam logic [1:0] L_IDLE = 2'd0;
   localparam logic [1:0] L_NORM = 2'd1;
   localparam logic [1:0] L_SQ   = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [31:0]      m_ff, m_in;
   logic [4:0]       n_ff, n_in;
   logic [4:0]       bit_ff, bit_in;
   logic [23:0]      frac_ff, frac_in;
   logic             done_ff, done_in;
   logic [63:0]      sq;
   logic [32:0]      t;

   always_comb begin
      sq       = {32'd0, m_ff} * {32'd0, m_ff};
      t        = sq[63:31];
      state_in = state_ff;
      m_in     = m_ff;
      n_in     = n_ff;
      bit_in   = bit_ff;
      frac_in  = frac_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               m_in     = x;
               n_in     = 5'd31;
               frac_in  = '0;
               bit_in   = 5'd23;
               state_in = L_NORM;
            end
         end
         L_NORM: begin
            // shift up until the top bit is set
            if (m_ff[31] || n_ff == 5'd0) begin
               state_in = L_SQ;
            end else begin
               m_in = {m_ff[30:0], 1'b0};
               n_in = n_ff - 1'b1;
            end
         end
         L_SQ: begin
            // square and renormalise; the overflow is the next fraction bit
            if (t[32]) begin
               m_in            = t[32:1];
               frac_in[bit_ff] = 1'b1;
            end else begin
               m_in = t[31:0];
            end
            bit_in = bit_ff - 1'b1;
            if (bit_ff == 5'd0) begin
               state_in = L_IDLE;
               done_in  = 1'b1;
            end
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff    <= m_in;
      n_ff    <= n_in;
      bit_ff  <= bit_in;
      frac_ff <= frac_in;
   end

   assign done   = done_ff;
   assign result = {n_ff, frac_ff};

endmodule
`default_nettype wire

>>> tb/tb_image_psnr_accumulator_top.sv
// Self-checking testbench for image_psnr_accumulator_top: drives pixel requests
// and register writes and checks each result against a scoreboard predictor.
// Depends on ipsnr_pkg and the RTL of the block.
`default_nettype none
module tb_image_psnr_accumulator_top;
   import ipsnr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIM_LIMIT = 4096;

   typedef struct {
      logic [1:0]        channel;
      logic [1:0]        status;
      logic [MSE_W-1:0]  mse;
      logic [PSNR_W-1:0] psnr_db;
      logic              psnr_infinite;
      logic              last;
   } psnr_result_type;

   typedef logic [2:0][SAMPLE_W-1:0] pixel_type;

   // Scoreboard: mirror of the registers and sums, queue of due results
   class psnr_scoreboard;
      logic [2:0]      fmt_a = FMT_RGB, fmt_b = FMT_RGB;
      logic [12:0]     wid_a = 1, hgt_a = 1, wid_b = 1, hgt_b = 1;
      longint unsigned sse[3];
      longint unsigned pixels;
      psnr_result_type due[$];
      int              errors;

      function void set_reg(logic [2:0] idx, logic [12:0] v);
         case (idx)
            REG_FORMAT_A: fmt_a = v[2:0];
            REG_FORMAT_B: fmt_b = v[2:0];
            REG_WIDTH_A:  wid_a = v;
            REG_HEIGHT_A: hgt_a = v;
            REG_WIDTH_B:  wid_b = v;
            REG_HEIGHT_B: hgt_b = v;
            default: ;
         endcase
      endfunction

      function logic [2:0] legal_fmt(logic [2:0] f);
         return (f > FMT_GRAYA) ? FMT_INVALID : f;
      endfunction

      function bit pair_ok(logic [2:0] x, logic [2:0] y);
         logic [2:0] lo, hi;
         lo = (x < y) ? x : y;
         hi = (x < y) ? y : x;
         return (x == y) || (lo == FMT_RGB && hi == FMT_RGBA)
            || (lo == FMT_BGR && hi == FMT_BGRA) || (lo == FMT_GRAY && hi == FMT_GRAYA);
      endfunction

      function longint unsigned clamp_dim(logic [12:0] d);
         if (d == 0) return 1;
         if (d > DIM_LIMIT) return DIM_LIMIT;
         return d;
      endfunction

      // log2 in Q.24: top bit index, then one fraction bit per squaring
      function longint unsigned log2_fix(logic [31:0] x);
         int              top;
         longint unsigned mant, acc;
         top = 31;
         while (top > 0 && !x[top]) top--;
         mant = longint'(x) << (31 - top);
         acc  = longint'(top) << 24;
         for (int i = 23; i >= 0; i--) begin
            mant = (mant * mant) >> 31;
            if (mant >= (64'd1 << 32)) begin
               mant = mant >> 1;
               acc  = acc | (64'd1 << i);
            end
         end
         return acc;
      endfunction

      function logic [PSNR_W-1:0] psnr_of(logic [31:0] mse);
         longint unsigned lr, lm, v;
         lr = log2_fix(PEAK_Q1616);
         lm = log2_fix(mse);
         if (lm >= lr) return 0;
         v = ((lr - lm) * longint'(K_Q30) + (64'd1 << 45)) >> 46;
         return (v > PSNR_MAX) ? PSNR_MAX : v[PSNR_W-1:0];
      endfunction

      function void clear_sums();
         sse = '{0, 0, 0};
         pixels = 0;
      endfunction

      // Take one accepted pixel request and queue what it causes
      function void note_request(pixel_type a, pixel_type b);
         logic [2:0]      fa, fb;
         logic [1:0]      st;
         psnr_result_type r;
         longint unsigned d, q;
         int              nres;
         fa = legal_fmt(fmt_a);
         fb = legal_fmt(fmt_b);
         st = ST_OK;
         if (!pair_ok(fa, fb)) st = ST_FORMAT;
         else if (wid_a != wid_b || hgt_a != hgt_b) st = ST_DIMS;
         else if (fa == FMT_INVALID) st = ST_INVALID;
         if (st != ST_OK) begin
            clear_sums();
            r = '{channel: 0, status: st, mse: 0, psnr_db: 0, psnr_infinite: 0, last: 1};
            due.push_back(r);
            return;
         end
         for (int c = 0; c < 3; c++) begin
            d = (a[c] >= b[c]) ? a[c] - b[c] : b[c] - a[c];
            sse[c] += d * d;
         end
         pixels++;
         if (pixels < clamp_dim(wid_a) * clamp_dim(hgt_a)) return;
         nres = (fa >= FMT_GRAY) ? 1 : 3;
         for (int k = 0; k < nres; k++) begin
            q = sse[k] / pixels;
            r.channel = k;
            r.status  = ST_OK;
            r.mse     = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
            r.psnr_infinite = (r.mse == 0);
            r.psnr_db = r.psnr_infinite ? PSNR_MAX : psnr_of(r.mse);
            r.last    = (k == nres - 1);
            due.push_back(r);
         end
         clear_sums();
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         errors++;
         $display("%0t ns: %s got %0d, want %0d", $realtime, what, got, want);
      endtask

      task check_result(psnr_result_type got);
         psnr_result_type want;
         if (due.size() == 0) begin
            report("unexpected result, channel", got.channel, 0);
            return;
         end
         want = due.pop_front();
         if (got.channel !== want.channel) report("channel", got.channel, want.channel);
         if (got.status !== want.status) report("status", got.status, want.status);
         if (got.mse !== want.mse) report("mse", got.mse, want.mse);
         if (got.psnr_db !== want.psnr_db) report("psnr_db", got.psnr_db, want.psnr_db);
         if (got.psnr_infinite !== want.psnr_infinite)
            report("psnr_infinite", got.psnr_infinite, want.psnr_infinite);
         if (got.last !== want.last) report("last", got.last, want.last);
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [SAMPLE_W-1:0] req_a_ch0 = '0, req_a_ch1 = '0, req_a_ch2 = '0;
   logic [SAMPLE_W-1:0] req_b_ch0 = '0, req_b_ch1 = '0, req_b_ch2 = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [1:0]          rsp_channel, rsp_status;
   logic [MSE_W-1:0]    rsp_mse;
   logic [PSNR_W-1:0]   rsp_psnr_db;
   logic                rsp_psnr_infinite, rsp_last;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [2:0]          csr_index = '0;
   logic [12:0]         csr_data = '0;

   psnr_scoreboard sb = new;
   bit calm;       // no idling on either side while set
   bit hold_go;    // ask the receiver for a long hold-off
   int rnd_items;

   image_psnr_accumulator_top dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: check accepted results, then choose the next stall
   int hold_left;
   always @(posedge clock) begin
      psnr_result_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_channel, rsp_status, rsp_mse, rsp_psnr_db, rsp_psnr_infinite,
                    rsp_last};
            sb.check_result(got);
         end
         if (hold_go) begin
            hold_go = 0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(99) < 36);
         end
      end
   end

   // Drain every due result, then let the block go quiet
   task drain();
      req_valid <= 1'b0;
      while (sb.due.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task write_reg(logic [2:0] idx, logic [12:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, v);
      csr_valid <= 1'b0;
   endtask

   // Registers are written only once the block has gone quiet
   task configure(logic [2:0] fa, logic [2:0] fb, logic [12:0] wa, logic [12:0] ha,
                  logic [12:0] wb, logic [12:0] hb);
      drain();
      write_reg(REG_FORMAT_A, fa);
      write_reg(REG_FORMAT_B, fb);
      write_reg(REG_WIDTH_A, wa);
      write_reg(REG_HEIGHT_A, ha);
      write_reg(REG_WIDTH_B, wb);
      write_reg(REG_HEIGHT_B, hb);
   endtask

   // Offer one pixel request, with a random idle gap in front of it
   task send_pixel(pixel_type a, pixel_type b);
      if (!calm && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_a_ch2, req_a_ch1, req_a_ch0} <= a;
      {req_b_ch2, req_b_ch1, req_b_ch0} <= b;
      do @(posedge clock); while (req_stall);
      sb.note_request(a, b);
   endtask

   function pixel_type rand_pixel();
      pixel_type p;
      for (int c = 0; c < 3; c++) p[c] = $urandom;
      return p;
   endfunction

   // Second image: equal, close to, or unrelated to the first
   function pixel_type near_pixel(pixel_type a);
      pixel_type p;
      int        mode;
      mode = $urandom_range(3);
      for (int c = 0; c < 3; c++)
         case (mode)
            0: p[c] = a[c];
            1, 2: p[c] = a[c] + $urandom_range(0, 600) - 300;
            default: p[c] = $urandom;
         endcase
      return p;
   endfunction

   task image_run(int n);
      pixel_type a;
      repeat (n) begin
         a = rand_pixel();
         send_pixel(a, near_pixel(a));
      end
   endtask

   initial begin
      logic [2:0]  fa, fb;
      logic [12:0] wa, ha;
      longint unsigned total;
      int n;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: default RGB 1x1, sample extremes
      send_pixel('0, '0);
      send_pixel({3{16'hFF00}}, '0);
      send_pixel({3{16'hFFFF}}, '0);
      send_pixel('0, {3{16'hFFFF}});
      send_pixel({16'd1, 16'd0, 16'h5555}, {16'd0, 16'd1, 16'hAAAA});
      drain();
      // Gray formats, two pixels each; then the BGR/BGRA and RGBA/RGB pairs
      configure(FMT_GRAY, FMT_GRAY, 2, 1, 2, 1);
      send_pixel({16'hFFFF, 16'hFFFF, 16'd3}, '0);
      send_pixel('0, '0);
      configure(FMT_GRAYA, FMT_GRAY, 2, 1, 2, 1);
      image_run(2);
      configure(FMT_BGR, FMT_BGRA, 1, 2, 1, 2);
      image_run(2);
      configure(FMT_RGBA, FMT_RGB, 1, 1, 1, 1);
      image_run(1);
      // Each configuration error, then unknown format code
      configure(FMT_RGB, FMT_GRAY, 1, 1, 1, 1);
      image_run(2);
      configure(FMT_BGRA, FMT_BGRA, 3, 1, 4, 1);
      image_run(2);
      configure(FMT_RGB, FMT_RGB, 3, 2, 3, 1);
      image_run(1);
      configure(FMT_INVALID, FMT_INVALID, 1, 1, 1, 1);
      image_run(2);
      configure(3'd7, FMT_INVALID, 1, 1, 1, 1);
      image_run(1);
      // Zero sizes count as one
      configure(FMT_BGRA, FMT_BGR, 0, 0, 0, 0);
      image_run(2);
      drain();
      // Largest sizes: all-ones registers clamp, so a few pixels complete nothing
      configure(FMT_RGB, FMT_RGB, 13'h1FFF, 1, 13'h1FFF, 1);
      image_run(4);
      drain();
      configure(FMT_GRAY, FMT_GRAY, 1, 13'h1FFF, 1, 13'h1FFF);
      image_run(4);
      drain();

      // Random phases
      for (int phase = 0; rnd_items < 190; phase++) begin
         calm = (phase >= 3 && phase < 6);
         if ($urandom_range(99) < 15) begin
            fa = $urandom;
            fb = $urandom;
            wa = $urandom_range(1, 4);
            ha = $urandom_range(1, 3);
            configure(fa, fb, wa, ha, $urandom_range(0, 1) ? wa : wa + 1, ha);
            n = $urandom_range(2, 5);
         end else begin
            fa = $urandom_range(FMT_RGB, FMT_GRAYA);
            case (fa)
               FMT_RGB:   fb = $urandom_range(0, 1) ? FMT_RGB : FMT_RGBA;
               FMT_RGBA:  fb = $urandom_range(0, 1) ? FMT_RGB : FMT_RGBA;
               FMT_BGR:   fb = $urandom_range(0, 1) ? FMT_BGR : FMT_BGRA;
               FMT_BGRA:  fb = $urandom_range(0, 1) ? FMT_BGR : FMT_BGRA;
               default:   fb = $urandom_range(0, 1) ? FMT_GRAY : FMT_GRAYA;
            endcase
            wa = $urandom_range(1, 4);
            ha = $urandom_range(1, 3);
            if (phase == 2) begin
               wa = 1;
               ha = 1;
            end
            configure(fa, fb, wa, ha, wa, ha);
            total = wa * ha;
            n = total * $urandom_range(1, 3);
            // sometimes leave an image half done across the next write
            if ($urandom_range(3) == 0) n += $urandom_range(0, total - 1);
         end
         // Receiver holds off while one-pixel images keep coming
         if (phase == 2) hold_go = 1;
         image_run(n);
         rnd_items += n;
         drain();
      end

      calm = 0;
      drain();
      repeat (400) @(posedge clock);
      if (sb.errors == 0 && sb.due.size() == 0)
         $display("image_psnr_accumulator_top: match");
      else
         $display("image_psnr_accumulator_top: mismatch");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("image_psnr_accumulator_top: mismatch");
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
src/ipsnr_pkg.sv
src/ipsnr_lane.sv
src/ipsnr_div.sv
src/ipsnr_log.sv
src/image_psnr_accumulator_top.sv
tb/tb_image_psnr_accumulator_top.sv
